FILE: hdl/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg: shared types and constants for the color temperature block
// Fixed-point widths, matrix coefficients, datapath command codes and the
// controller state encoding.
// ----------------------------------------------------------------------------
package rct_pkg;

   localparam int IN_W       = 16;
   localparam int V_W        = 17;
   localparam int CH_W       = 17;
   localparam int AVG_W      = 24;
   localparam int COEF_W     = 18;
   localparam int T_W        = 36;
   localparam int S_W        = 37;
   localparam int ND_W       = 50;
   localparam int N_W        = 21;
   localparam int N2_W       = 24;
   localparam int N3_W       = 27;
   localparam int TT_W       = 44;
   localparam int ILL_W      = 19;
   localparam int CXY_W      = 16;
   localparam int CCT_W      = 16;
   localparam int STAT_W     = 2;
   localparam int PCT_W      = 32;

   // shared restoring divider: quotient capped at DIV_QW bits
   localparam int DIV_AW     = 66;
   localparam int DIV_BW     = 50;
   localparam int DIV_QW     = 20;
   localparam int DIV_RW     = DIV_BW + DIV_QW;
   localparam int DIV_CNT_W  = $clog2(DIV_QW + 1);

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam int MAC_N      = 9;
   localparam int MAC_W      = 4;

   localparam logic [CSR_IDX_W-1:0] REG_COMPENSATE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERCENTAGE = 4'd1;

   typedef logic signed [COEF_W-1:0] coef_type;

   // XYZ matrix, Q16, row-major (X, Y, Z) over (red, green, blue)
   localparam coef_type COEF [MAC_N] = '{
      -18'sd9360,  18'sd101531, -18'sd62679,
      -18'sd21277, 18'sd103440, -18'sd47966,
      -18'sd44697, 18'sd50511,   18'sd36918
   };

   localparam logic [16:0]          BLUE_SCALE = 17'd104681;
   localparam logic [14:0]          PCT_SCALE  = 15'd25600;
   localparam logic [21:0]          CCT_ROUND  = 22'd3276800;
   // kelvin = (tt + round) / (100 * 2^16): shift, then divide by 100 with
   // ceil(2^30 / 100), exact below the saturation point
   localparam logic [23:0]          CCT_RECIP  = 24'd10737419;
   localparam logic [27:0]          CCT_SAT_X  = 28'd6553600;
   localparam logic [AVG_W-1:0]     AVG_MAX    = '1;

   localparam logic signed [15:0]   K_10000    = 16'sd10000;
   localparam logic signed [15:0]   K_3320     = 16'sd3320;
   localparam logic signed [15:0]   K_1858     = 16'sd1858;
   localparam logic signed [21:0]   K_TT3      = 22'sd44900;
   localparam logic signed [21:0]   K_TT2      = 22'sd352500;
   localparam logic signed [21:0]   K_TT1      = 22'sd682330;
   localparam logic signed [TT_W-1:0] TT_OFFSET = 44'sd36178034688;

   localparam logic [DIV_QW-1:0]    CXY_CAP_POS = 20'd32767;
   localparam logic [DIV_QW-1:0]    CXY_CAP_NEG = 20'd32768;
   localparam logic [DIV_QW-1:0]    N_CAP       = 20'd524288;
   localparam logic [DIV_QW-1:0]    CH_CAP      = 20'd131071;
   localparam logic [CH_W-1:0]      CH_MAX      = '1;

   localparam logic [20:0]          ILL_MAG_POS = 21'd262143;
   localparam logic [20:0]          ILL_MAG_NEG = 21'd262144;
   localparam logic signed [ILL_W-1:0] ILL_MAX  = 19'sd262143;
   localparam logic signed [ILL_W-1:0] ILL_MIN  = {1'b1, {(ILL_W-1){1'b0}}};

   typedef enum logic [3:0] {
      OP_NOP, OP_LOAD, OP_AVG, OP_MAC, OP_SUM, OP_NUM, OP_DEN,
      OP_DSTART, OP_DSTORE, OP_N2, OP_N3, OP_TT1, OP_TT2, OP_OUT
   } op_type;

   // P0..P3 must stay at codes 4..7: the low bits pick the channel
   typedef enum logic [2:0] {
      DIV_CX, DIV_CY, DIV_N, DIV_CCT, DIV_P0, DIV_P1, DIV_P2, DIV_P3
   } divsel_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AVG, ST_MAC, ST_SUM, ST_NUM, ST_DEN, ST_DSTART, ST_DWAIT,
      ST_DSTORE, ST_N2, ST_N3, ST_TT1, ST_TT2, ST_OUT
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [MAC_W-1:0] mac_idx;
      divsel_type       dsel;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

   function automatic logic [1:0] coef_row(input logic [MAC_W-1:0] idx);
      logic [1:0] r;
      case (idx)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] coef_col(input logic [MAC_W-1:0] idx);
      logic [1:0] c;
      case (idx)
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/rct_if.sv
// ----------------------------------------------------------------------------
// rct_if: channel interfaces
// Sample set input, result output and register write channels.
// ----------------------------------------------------------------------------
interface rct_req_if;
   import rct_pkg::*;
   logic            valid;
   logic            ready;
   logic [IN_W-1:0] clear_count;
   logic [IN_W-1:0] red_count;
   logic [IN_W-1:0] green_count;
   logic [IN_W-1:0] blue_count;
   modport source (output valid, clear_count, red_count, green_count, blue_count,
                   input ready);
   modport sink   (input valid, clear_count, red_count, green_count, blue_count,
                   output ready);
endinterface

interface rct_rsp_if;
   import rct_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CH_W-1:0]         clear_out;
   logic [CH_W-1:0]         red_out;
   logic [CH_W-1:0]         green_out;
   logic [CH_W-1:0]         blue_out;
   logic signed [ILL_W-1:0] illuminance;
   logic signed [CXY_W-1:0] chroma_x;
   logic signed [CXY_W-1:0] chroma_y;
   logic [CCT_W-1:0]        cct_kelvin;
   logic [STAT_W-1:0]       status;
   modport source (output valid, clear_out, red_out, green_out, blue_out, illuminance,
                   chroma_x, chroma_y, cct_kelvin, status, input ready);
   modport sink   (input valid, clear_out, red_out, green_out, blue_out, illuminance,
                   chroma_x, chroma_y, cct_kelvin, status, output ready);
endinterface

interface rct_csr_if;
   import rct_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/rct_divider.sv
// ----------------------------------------------------------------------------
// rct_divider: shared restoring divider
// Unsigned quotient, one bit per cycle, with an overflow flag when the
// quotient does not fit in DIV_QW bits.
// ----------------------------------------------------------------------------
module rct_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rct_pkg::DIV_AW-1:0]   dividend,
   input  logic [rct_pkg::DIV_BW-1:0]   divisor,
   output logic [rct_pkg::DIV_QW-1:0]   quotient,
   output logic                         overflow,
   output logic                         done
);
   import rct_pkg::*;

   logic [DIV_RW-1:0]    rem_ff, rem_in;
   logic [DIV_RW-1:0]    dvs_ff, dvs_in;
   logic [DIV_QW-1:0]    q_ff, q_in;
   logic                 ovf_ff, ovf_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      q_in   = q_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = DIV_RW'(dividend);
         dvs_in = DIV_RW'(divisor) << (DIV_QW - 1);
         q_in   = '0;
         ovf_in = (dividend >> DIV_QW) >= DIV_AW'(divisor);
         cnt_in = DIV_CNT_W'(DIV_QW);
      end else if (cnt_ff != '0) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            q_in   = {q_ff[DIV_QW-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[DIV_QW-2:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign quotient = q_ff;
   assign overflow = ovf_ff;
   assign done     = (cnt_ff == '0);

endmodule

FILE: hdl/rct_datapath.sv
// ----------------------------------------------------------------------------
// rct_datapath: color temperature datapath
// Compensation, running averages, XYZ matrix, chromaticity, CCT cubic and
// percentage, one command per cycle from the controller.
// ----------------------------------------------------------------------------
module rct_datapath #(
   parameter int AVERAGE_SHIFT = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rct_pkg::cmd_type                 cmd,
   output rct_pkg::stat_type                stat,
   input  logic [rct_pkg::IN_W-1:0]         clear_count,
   input  logic [rct_pkg::IN_W-1:0]         red_count,
   input  logic [rct_pkg::IN_W-1:0]         green_count,
   input  logic [rct_pkg::IN_W-1:0]         blue_count,
   input  logic                             csr_write,
   input  logic [rct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rct_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [rct_pkg::CH_W-1:0]         clear_out,
   output logic [rct_pkg::CH_W-1:0]         red_out,
   output logic [rct_pkg::CH_W-1:0]         green_out,
   output logic [rct_pkg::CH_W-1:0]         blue_out,
   output logic signed [rct_pkg::ILL_W-1:0] illuminance,
   output logic signed [rct_pkg::CXY_W-1:0] chroma_x,
   output logic signed [rct_pkg::CXY_W-1:0] chroma_y,
   output logic [rct_pkg::CCT_W-1:0]        cct_kelvin,
   output logic [rct_pkg::STAT_W-1:0]       status
);
   import rct_pkg::*;

   localparam int AS_W  = AVG_W + AVERAGE_SHIFT + 2;
   localparam int P2_W  = 2 * N_W;
   localparam int P3_W  = N2_W + N_W;

   logic                    comp_ff, comp_in, pct_ff, pct_in;
   logic [V_W-1:0]          v_ff [4];
   logic [V_W-1:0]          v_in [4];
   logic [AVG_W-1:0]        avg_ff [4];
   logic [AVG_W-1:0]        avg_in [4];
   logic signed [T_W-1:0]   t_ff [3];
   logic signed [T_W-1:0]   t_in [3];
   logic signed [S_W-1:0]   s_ff, s_in;
   logic signed [ND_W-1:0]  num_ff, num_in, den_ff, den_in;
   logic signed [N_W-1:0]   n_ff, n_in;
   logic signed [N2_W-1:0]  n2_ff, n2_in;
   logic signed [N3_W-1:0]  n3_ff, n3_in;
   logic signed [TT_W-1:0]  tt_ff, tt_in;
   logic signed [CXY_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [CCT_W-1:0]        cct_ff, cct_in;
   logic [CH_W-1:0]         o_ff [4];
   logic [CH_W-1:0]         o_in [4];
   logic                    pz_ff, pz_in;

   logic [CH_W-1:0]         rc_ff, rr_ff, rg_ff, rb_ff;
   logic signed [ILL_W-1:0] rill_ff;
   logic signed [CXY_W-1:0] rcx_ff, rcy_ff;
   logic [CCT_W-1:0]        rcct_ff;
   logic [STAT_W-1:0]       rst_ff;
   logic                    out_load;

   // helpers
   logic [20:0]             g21;
   logic [V_W-1:0]          green_scaled, blue_scaled;
   logic [32:0]             blue_prod;
   logic [AS_W-1:0]         avg_sum [4];
   logic [AS_W-1:0]         avg_shr [4];
   logic [1:0]              mac_r, mac_c;
   logic [V_W-1:0]          mac_v;
   logic signed [T_W-1:0]   mac_prod;
   logic [T_W-1:0]          abs_t0, abs_t1;
   logic [S_W-1:0]          abs_s;
   logic [ND_W-1:0]         abs_num, abs_den;
   logic [1:0]              pct_sel;
   logic [V_W-1:0]          pct_v;
   logic [PCT_W-1:0]        pct_prod;
   logic                    s_zero, den_zero, tt_pos;
   logic [DIV_AW-1:0]       div_a;
   logic [DIV_BW-1:0]       div_b;
   logic                    div_neg;
   logic [DIV_QW-1:0]       div_q, div_cap, div_m;
   logic                    div_ovf, div_done;
   logic signed [DIV_QW:0]  div_sm;
   logic signed [P2_W-1:0]  n2_prod;
   logic signed [P3_W-1:0]  n3_prod, n3_adj;
   logic [20:0]             ill_mag;
   logic signed [ILL_W-1:0] ill_val;
   logic [TT_W-1:0]         cct_sum;
   logic [TT_W-17:0]        cct_x;
   logic [46:0]             cct_prod;
   logic [CCT_W-1:0]        cct_q;

   assign g21          = (21'(green_count) << 4) + (21'(green_count) << 2) + 21'(green_count);
   assign green_scaled = V_W'(g21 >> 4);
   assign blue_prod    = 33'(blue_count) * 33'(BLUE_SCALE);
   assign blue_scaled  = V_W'(blue_prod >> 16);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         avg_sum[i] = (AS_W'(avg_ff[i]) << AVERAGE_SHIFT) - AS_W'(avg_ff[i])
                      + (AS_W'(v_ff[i]) << 8);
         avg_shr[i] = avg_sum[i] >> AVERAGE_SHIFT;
      end
   end

   assign mac_r    = coef_row(cmd.mac_idx);
   assign mac_c    = coef_col(cmd.mac_idx);
   assign mac_v    = v_ff[2'(mac_c + 2'd1)];
   assign mac_prod = T_W'(COEF[cmd.mac_idx]) * T_W'($signed({1'b0, mac_v}));

   assign abs_t0  = t_ff[0][T_W-1] ? T_W'(-t_ff[0]) : T_W'(t_ff[0]);
   assign abs_t1  = t_ff[1][T_W-1] ? T_W'(-t_ff[1]) : T_W'(t_ff[1]);
   assign abs_s   = s_ff[S_W-1] ? S_W'(-s_ff) : S_W'(s_ff);
   assign abs_num = num_ff[ND_W-1] ? ND_W'(-num_ff) : ND_W'(num_ff);
   assign abs_den = den_ff[ND_W-1] ? ND_W'(-den_ff) : ND_W'(den_ff);

   assign pct_sel  = cmd.dsel[1:0];
   assign pct_v    = v_ff[pct_sel];
   assign pct_prod = PCT_W'(pct_v) * PCT_W'(PCT_SCALE);

   assign s_zero   = (s_ff == '0);
   assign den_zero = (den_ff == '0);
   assign tt_pos   = !tt_ff[TT_W-1] && (tt_ff != '0);

   // rounded kelvin from the cubic, only used while tt is positive
   assign cct_sum  = TT_W'(tt_ff) + TT_W'(CCT_ROUND);
   assign cct_x    = cct_sum[TT_W-1:16];
   assign cct_prod = 47'(cct_x[22:0]) * 47'(CCT_RECIP);
   assign cct_q    = (cct_x >= CCT_SAT_X) ? '1 : CCT_W'(cct_prod >> 30);

   // divider operands and result cap per division
   always_comb begin
      div_a   = '0;
      div_b   = '0;
      div_neg = 1'b0;
      div_cap = CH_CAP;
      case (cmd.dsel)
         DIV_CX: begin
            div_a   = DIV_AW'(abs_t0) << 14;
            div_b   = DIV_BW'(abs_s);
            div_neg = t_ff[0][T_W-1] ^ s_ff[S_W-1];
            div_cap = div_neg ? CXY_CAP_NEG : CXY_CAP_POS;
         end
         DIV_CY: begin
            div_a   = DIV_AW'(abs_t1) << 14;
            div_b   = DIV_BW'(abs_s);
            div_neg = t_ff[1][T_W-1] ^ s_ff[S_W-1];
            div_cap = div_neg ? CXY_CAP_NEG : CXY_CAP_POS;
         end
         DIV_N: begin
            div_a   = DIV_AW'(abs_num) << 16;
            div_b   = abs_den;
            div_neg = num_ff[ND_W-1] ^ den_ff[ND_W-1];
            div_cap = N_CAP;
         end
         default: begin
            div_a   = DIV_AW'(pct_prod);
            div_b   = DIV_BW'(avg_ff[pct_sel]);
            div_cap = CH_CAP;
         end
      endcase
      div_m  = (div_ovf || div_q > div_cap) ? div_cap : div_q;
      div_sm = div_neg ? -$signed({1'b0, div_m}) : $signed({1'b0, div_m});
   end

   rct_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DSTART),
      .dividend (div_a),
      .divisor  (div_b),
      .quotient (div_q),
      .overflow (div_ovf),
      .done     (div_done)
   );

   assign stat.div_done = div_done;

   assign n2_prod = P2_W'(n_ff) * P2_W'(n_ff);
   assign n3_prod = P3_W'(n2_ff) * P3_W'(n_ff);
   // bias negative products so the shift truncates toward zero
   assign n3_adj  = n3_prod + $signed({{(P3_W-16){1'b0}}, {16{n3_prod[P3_W-1]}}});

   always_comb begin
      ill_mag = 21'(({1'b0, abs_t1} + 37'd32768) >> 16);
      if (!t_ff[1][T_W-1]) begin
         ill_val = (ill_mag > ILL_MAG_POS) ? ILL_MAX : ILL_W'(ill_mag);
      end else begin
         ill_val = (ill_mag > ILL_MAG_NEG) ? ILL_MIN : ILL_W'(21'd0 - ill_mag);
      end
   end

   always_comb begin
      comp_in = comp_ff;
      pct_in  = pct_ff;
      v_in    = v_ff;
      avg_in  = avg_ff;
      t_in    = t_ff;
      s_in    = s_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      n_in    = n_ff;
      n2_in   = n2_ff;
      n3_in   = n3_ff;
      tt_in   = tt_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cct_in  = cct_ff;
      o_in    = o_ff;
      pz_in   = pz_ff;
      out_load = 1'b0;
      if (csr_write && csr_index == REG_COMPENSATE) begin
         comp_in = csr_data[0];
      end
      if (csr_write && csr_index == REG_PERCENTAGE) begin
         pct_in = csr_data[0];
      end
      case (cmd.op)
         OP_LOAD: begin
            v_in[0] = V_W'(clear_count);
            v_in[1] = V_W'(red_count);
            v_in[2] = comp_ff ? green_scaled : V_W'(green_count);
            v_in[3] = comp_ff ? blue_scaled : V_W'(blue_count);
            pz_in   = 1'b0;
         end
         OP_AVG: begin
            for (int i = 0; i < 4; i++) begin
               avg_in[i] = (avg_shr[i][AS_W-1:AVG_W] != '0) ? AVG_MAX
                                                            : AVG_W'(avg_shr[i]);
            end
         end
         OP_MAC: begin
            if (mac_c == 2'd0) begin
               t_in[mac_r] = mac_prod;
            end else begin
               t_in[mac_r] = t_ff[mac_r] + mac_prod;
            end
         end
         OP_SUM: s_in = S_W'(t_ff[0]) + S_W'(t_ff[1]) + S_W'(t_ff[2]);
         OP_NUM: num_in = ND_W'(t_ff[0]) * ND_W'(K_10000) - ND_W'(s_ff) * ND_W'(K_3320);
         OP_DEN: den_in = ND_W'(s_ff) * ND_W'(K_1858) - ND_W'(t_ff[1]) * ND_W'(K_10000);
         OP_DSTORE: begin
            case (cmd.dsel)
               DIV_CX:  cx_in = s_zero ? '0 : CXY_W'(div_sm);
               DIV_CY:  cy_in = s_zero ? '0 : CXY_W'(div_sm);
               DIV_N:   n_in  = N_W'(div_sm);
               DIV_CCT: cct_in = (s_zero || den_zero || !tt_pos) ? '0 : cct_q;
               default: begin
                  if (!pct_ff) begin
                     o_in[pct_sel] = CH_W'(pct_v);
                  end else if (avg_ff[pct_sel] == '0) begin
                     o_in[pct_sel] = CH_MAX;
                     pz_in         = 1'b1;
                  end else begin
                     o_in[pct_sel] = CH_W'(div_m);
                  end
               end
            endcase
         end
         OP_N2:  n2_in = N2_W'(n2_prod >>> 16);
         OP_N3:  n3_in = N3_W'(n3_adj >>> 16);
         OP_TT1: tt_in = TT_W'(n3_ff) * TT_W'(K_TT3) + TT_W'(n2_ff) * TT_W'(K_TT2);
         OP_TT2: tt_in = tt_ff + TT_W'(n_ff) * TT_W'(K_TT1) + TT_OFFSET;
         OP_OUT: out_load = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff <= 1'b0;
         pct_ff  <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            avg_ff[i] <= '0;
         end
      end else begin
         comp_ff <= comp_in;
         pct_ff  <= pct_in;
         avg_ff  <= avg_in;
      end
      v_ff   <= v_in;
      t_ff   <= t_in;
      s_ff   <= s_in;
      num_ff <= num_in;
      den_ff <= den_in;
      n_ff   <= n_in;
      n2_ff  <= n2_in;
      n3_ff  <= n3_in;
      tt_ff  <= tt_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      cct_ff <= cct_in;
      o_ff   <= o_in;
      pz_ff  <= pz_in;
      if (out_load) begin
         rc_ff   <= o_ff[0];
         rr_ff   <= o_ff[1];
         rg_ff   <= o_ff[2];
         rb_ff   <= o_ff[3];
         rill_ff <= ill_val;
         rcx_ff  <= cx_ff;
         rcy_ff  <= cy_ff;
         rcct_ff <= cct_ff;
         rst_ff  <= {pz_ff, s_zero || den_zero};
      end
   end

   assign clear_out   = rc_ff;
   assign red_out     = rr_ff;
   assign green_out   = rg_ff;
   assign blue_out    = rb_ff;
   assign illuminance = rill_ff;
   assign chroma_x    = rcx_ff;
   assign chroma_y    = rcy_ff;
   assign cct_kelvin  = rcct_ff;
   assign status      = rst_ff;

endmodule

FILE: hdl/rct_ctrl.sv
// ----------------------------------------------------------------------------
// rct_ctrl: sequencer for the color temperature datapath
// Steps one word through load, average, matrix, the divisions and the
// cubic, then hands it to the result register.
// ----------------------------------------------------------------------------
module rct_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  rct_pkg::stat_type  stat,
   output rct_pkg::cmd_type   cmd
);
   import rct_pkg::*;

   state_type        state_ff, state_in;
   logic [MAC_W-1:0] mac_ff, mac_in;
   divsel_type       dsel_ff, dsel_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mac_ff       <= '0;
         dsel_ff      <= DIV_CX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mac_ff       <= mac_in;
         dsel_ff      <= dsel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mac_in       = mac_ff;
      dsel_in      = dsel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NOP;
      cmd.mac_idx  = mac_ff;
      cmd.dsel     = dsel_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            cmd.op   = OP_AVG;
            mac_in   = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            cmd.op = OP_MAC;
            if (mac_ff == MAC_W'(MAC_N - 1)) begin
               state_in = ST_SUM;
            end else begin
               mac_in = MAC_W'(mac_ff + 1'b1);
            end
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            cmd.op   = OP_NUM;
            state_in = ST_DEN;
         end
         ST_DEN: begin
            cmd.op   = OP_DEN;
            dsel_in  = DIV_CX;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            cmd.op   = OP_DSTART;
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (stat.div_done) begin
               state_in = ST_DSTORE;
            end
         end
         ST_DSTORE: begin
            cmd.op = OP_DSTORE;
            case (dsel_ff)
               DIV_N:   state_in = ST_N2;
               DIV_P3:  state_in = ST_OUT;
               default: begin
                  dsel_in  = divsel_type'(3'(dsel_ff + 3'd1));
                  state_in = ST_DSTART;
               end
            endcase
         end
         ST_N2: begin
            cmd.op   = OP_N2;
            state_in = ST_N3;
         end
         ST_N3: begin
            cmd.op   = OP_N3;
            state_in = ST_TT1;
         end
         ST_TT1: begin
            cmd.op   = OP_TT1;
            state_in = ST_TT2;
         end
         ST_TT2: begin
            // kelvin scaling needs no divider pass
            cmd.op   = OP_TT2;
            dsel_in  = DIV_CCT;
            state_in = ST_DSTORE;
         end
         ST_OUT: begin
            // result register free once the previous word has gone
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/rgb_color_temperature_top.sv
// ----------------------------------------------------------------------------
// rgb_color_temperature_top: color temperature from clear/red/green/blue counts
// Top level: sequencer, datapath and channel ports.
// ----------------------------------------------------------------------------
// Each accepted word of four counts steps through average, matrix
// multiply-accumulate, sum and McCamy terms, then the x, y and McCamy n
// divisions, the cubic, the kelvin scaling, four percentage divisions and
// the load of the output register; all seven divisions run on one shared
// bit-serial divider. One word is in flight at a time, so a word is taken
// only once the last one is through; a finished result waits in its output
// register, and the next word is taken while it waits, but a result still
// unread when the next one is done stalls that word. Registers write on
// csr_bus (csr ready is always high); write them between words.
module rgb_color_temperature_top #(
   parameter int AVERAGE_SHIFT = 2
) (
   input logic       clock,
   input logic       reset,
   rct_req_if.sink   req_bus,
   rct_rsp_if.source rsp_bus,
   rct_csr_if.sink   csr_bus
);
   import rct_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_bus.ready = 1'b1;

   rct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rct_datapath #(
      .AVERAGE_SHIFT (AVERAGE_SHIFT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .clear_count (req_bus.clear_count),
      .red_count   (req_bus.red_count),
      .green_count (req_bus.green_count),
      .blue_count  (req_bus.blue_count),
      .csr_write   (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .clear_out   (rsp_bus.clear_out),
      .red_out     (rsp_bus.red_out),
      .green_out   (rsp_bus.green_out),
      .blue_out    (rsp_bus.blue_out),
      .illuminance (rsp_bus.illuminance),
      .chroma_x    (rsp_bus.chroma_x),
      .chroma_y    (rsp_bus.chroma_y),
      .cct_kelvin  (rsp_bus.cct_kelvin),
      .status      (rsp_bus.status)
   );

endmodule

FILE: tb/rct_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_tb_if: testbench side of the channel interfaces
// The channel interfaces come with the RTL (rct_if.sv); this file only holds
// the sample set and result records that the testbench queues.
// ----------------------------------------------------------------------------
package rct_tb_pkg;
   import rct_pkg::*;

   typedef struct packed {
      logic [IN_W-1:0] clear_count;
      logic [IN_W-1:0] red_count;
      logic [IN_W-1:0] green_count;
      logic [IN_W-1:0] blue_count;
   } sample_set_type;

   typedef struct packed {
      logic [CH_W-1:0]         clear_out;
      logic [CH_W-1:0]         red_out;
      logic [CH_W-1:0]         green_out;
      logic [CH_W-1:0]         blue_out;
      logic signed [ILL_W-1:0] illuminance;
      logic signed [CXY_W-1:0] chroma_x;
      logic signed [CXY_W-1:0] chroma_y;
      logic [CCT_W-1:0]        cct_kelvin;
      logic [STAT_W-1:0]       status;
   } color_result_type;
endpackage

FILE: tb/rgb_color_temperature_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_temperature_top_tb: self-checking bench for the color temperature block
// Drives count sets through several register settings and idle/stall mixes,
// predicts every result with a local fixed-point model and compares in order.
// ----------------------------------------------------------------------------
module rgb_color_temperature_top_tb;
   import rct_pkg::*;
   import rct_tb_pkg::*;

   localparam int AVG_SHIFT = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rct_req_if req_bus();
   rct_rsp_if rsp_bus();
   rct_csr_if csr_bus();

   rgb_color_temperature_top #(.AVERAGE_SHIFT(AVG_SHIFT)) dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   always #10 clock = ~clock;

   sample_set_type   pending_sets[$];
   color_result_type expected_results[$];
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   errors = 0;
   bit   req_fire = 0;

   // predictor state
   logic [AVG_W-1:0] avg_model[4];
   bit               comp_model = 0;
   bit               pct_model = 0;

   function automatic longint fix_div(longint unsigned a, longint unsigned b, int frac,
                                      longint unsigned cap);
      longint unsigned q, r;
      q = a / b;
      r = a % b;
      if (q > (cap >> frac)) return cap;
      for (int i = 0; i < frac; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= b) begin
            r = r - b;
            q = q | 1;
         end
      end
      return (q > cap) ? cap : q;
   endfunction

   function automatic longint signed_div(longint num, longint den, int frac,
                                         longint unsigned pcap, longint unsigned ncap);
      bit neg;
      longint unsigned m;
      neg = (num < 0) != (den < 0);
      m = fix_div(num < 0 ? -num : num, den < 0 ? -den : den, frac, neg ? ncap : pcap);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic color_result_type predict_color(sample_set_type s);
      color_result_type r;
      longint v[4];
      longint t[3];
      longint sum, ill, cx, cy, num, den, n, n2, n3, tt, o, a;
      longint unsigned mag, cct;
      logic [STAT_W-1:0] st;
      v[0] = s.clear_count; v[1] = s.red_count;
      v[2] = s.green_count; v[3] = s.blue_count;
      st = '0; cx = 0; cy = 0; cct = 0;
      if (comp_model) begin
         v[2] = (v[2] * 21) >>> 4;
         v[3] = (v[3] * 104681) >>> 16;
      end
      for (int i = 0; i < 4; i++) begin
         a = (((1 << AVG_SHIFT) - 1) * longint'(avg_model[i]) + (v[i] << 8)) >>> AVG_SHIFT;
         avg_model[i] = (a > 64'hFFFFFF) ? 24'hFFFFFF : a[AVG_W-1:0];
      end
      for (int k = 0; k < 3; k++)
         t[k] = longint'(COEF[3*k]) * v[1] + longint'(COEF[3*k+1]) * v[2]
              + longint'(COEF[3*k+2]) * v[3];
      sum = t[0] + t[1] + t[2];
      mag = (t[1] < 0) ? -t[1] : t[1];
      mag = (mag + 32768) >> 16;
      ill = (t[1] < 0) ? -longint'(mag) : longint'(mag);
      if (ill > 262143) ill = 262143;
      if (ill < -262144) ill = -262144;
      if (sum == 0) st[0] = 1'b1;
      else begin
         num = 10000 * t[0] - 3320 * sum;
         den = 1858 * sum - 10000 * t[1];
         cx = signed_div(t[0], sum, 14, 32767, 32768);
         cy = signed_div(t[1], sum, 14, 32767, 32768);
         if (den == 0) st[0] = 1'b1;
         else begin
            n  = signed_div(num, den, 16, 524288, 524288);
            n2 = (n * n) / 65536;
            n3 = (n2 * n) / 65536;
            tt = 44900 * n3 + 352500 * n2 + 682330 * n + longint'(552033) * 65536;
            if (tt > 0) begin
               cct = (longint'(tt) + 3276800) / 6553600;
               if (cct > 65535) cct = 65535;
            end
         end
      end
      for (int i = 0; i < 4; i++) begin
         o = v[i];
         if (pct_model) begin
            if (avg_model[i] == 0) begin
               o = 131071;
               st[1] = 1'b1;
            end else o = (v[i] * 25600) / longint'(avg_model[i]);
         end
         if (o > 131071) o = 131071;
         case (i)
            0: r.clear_out = o[CH_W-1:0];
            1: r.red_out   = o[CH_W-1:0];
            2: r.green_out = o[CH_W-1:0];
            default: r.blue_out = o[CH_W-1:0];
         endcase
      end
      r.illuminance = ill[ILL_W-1:0];
      r.chroma_x    = cx[CXY_W-1:0];
      r.chroma_y    = cy[CXY_W-1:0];
      r.cct_kelvin  = cct[CCT_W-1:0];
      r.status      = st;
      return r;
   endfunction

   // driver
   initial begin
      req_bus.valid = 1'b0;
      {req_bus.clear_count, req_bus.red_count, req_bus.green_count, req_bus.blue_count} = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_COMPENSATE;
      csr_bus.data  = '0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_bus.valid && !req_fire) begin
            // hold word until taken
         end else if (pending_sets.size() > 0 &&
                      $urandom_range(99, 0) >= send_idle_pct) begin
            {req_bus.clear_count, req_bus.red_count, req_bus.green_count,
             req_bus.blue_count} <= pending_sets[0];
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // accepted words feed the predictor; results are checked here
   always @(posedge clock) begin
      color_result_type got, want;
      req_fire = !reset && req_bus.valid && req_bus.ready;
      if (req_fire) begin
         expected_results.push_back(predict_color(pending_sets.pop_front()));
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.clear_out, rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out,
                 rsp_bus.illuminance, rsp_bus.chroma_x, rsp_bus.chroma_y,
                 rsp_bus.cct_kelvin, rsp_bus.status};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %p", $time, want);
               $display("%0t:          actual   %p", $time, got);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, bit val);
      @(negedge clock);
      csr_bus.index <= idx;
      csr_bus.data  <= {7'd0, val};
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == REG_COMPENSATE) comp_model = val;
      else pct_model = val;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_sets.size() > 0 || expected_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [IN_W-1:0] rand_count();
      case ($urandom_range(5, 0))
         0: return '0;
         1: return '1;
         2: return $urandom_range(255, 0);
         default: return $urandom();
      endcase
   endfunction

   task automatic add_set(logic [IN_W-1:0] c, r, g, b);
      pending_sets.push_back('{c, r, g, b});
   endtask

   initial begin
      for (int i = 0; i < 4; i++) avg_model[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first word with zero averages and percentage on: zero base flagged
      write_reg(REG_PERCENTAGE, 1'b1);
      add_set(16'd0, 16'd0, 16'd0, 16'd0);
      add_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_set(16'd0, 16'd0, 16'd0, 16'd0);
      wait_drained();
      write_reg(REG_PERCENTAGE, 1'b0);
      write_reg(REG_COMPENSATE, 1'b1);
      add_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_set(16'd0, 16'hFFFF, 16'd0, 16'd0);
      add_set(16'd0, 16'd0, 16'hFFFF, 16'd0);
      add_set(16'd0, 16'd0, 16'd0, 16'hFFFF);
      add_set(16'd1, 16'd1, 16'd1, 16'd1);
      wait_drained();
      write_reg(REG_COMPENSATE, 1'b0);
      add_set(16'd0, 16'hFFFF, 16'd0, 16'd0);
      add_set(16'd0, 16'd0, 16'hFFFF, 16'd0);
      add_set(16'd0, 16'd0, 16'd0, 16'hFFFF);
      add_set(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
      add_set(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
      add_set(16'd100, 16'd300, 16'd400, 16'd200);
      add_set(16'd100, 16'd200, 16'd200, 16'd200);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 26 : 56) : 0;
         recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 26 : 56) : 0;
         write_reg(REG_COMPENSATE, ph[0]);
         write_reg(REG_PERCENTAGE, ph[1]);
         for (int i = 0; i < 60; i++)
            add_set(rand_count(), rand_count(), rand_count(), rand_count());
         wait_drained();
      end
      repeat (250) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule

FILE: files.f
hdl/rct_pkg.sv
hdl/rct_if.sv
hdl/rct_divider.sv
hdl/rct_datapath.sv
hdl/rct_ctrl.sv
hdl/rgb_color_temperature_top.sv
tb/rct_tb_if.sv
tb/rgb_color_temperature_top_tb.sv
